>>> sv/ps2mpt_pkg.sv
// shared types and constants for the ps2 mouse packet tracker
package ps2mpt_pkg;

	localparam int BOUND_BITS   = 13;
	localparam int INDEX_BITS   = 2;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int WIDTH_RESET  = 1920;
	localparam int HEIGHT_RESET = 1080;

	localparam logic [INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam int SYNC_BIT    = 3;
	localparam int X_SIGN_BIT  = 4;
	localparam int Y_SIGN_BIT  = 5;
	localparam int X_OVFL_BIT  = 6;
	localparam int Y_OVFL_BIT  = 7;

	typedef struct packed {
		logic signed [8:0] move_x;
		logic signed [9:0] move_y;
		logic [2:0]        button_bits;
	} pkt_t;

	typedef struct packed {
		logic                  valid;
		logic [INDEX_BITS-1:0] index;
		logic [BOUND_BITS-1:0] data;
	} cfg_wr_t;

endpackage

>>> sv/ps2_mouse_packet_tracker.sv
// top level: ps2 mouse packet decoder with clamped cursor tracking
// out_valid rises after the packet, queued on its third byte, is popped and registered
// throughput: one byte per cycle, one packet per cycle out of the four-entry queue,
// each while not stalled; in_stall rises only while the packet queue is full
// reset: packet phase cleared, bounds 1920 by 1080, cursor at 960,540 clamped to bounds
module ps2_mouse_packet_tracker #(
	parameter int POSITION_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   byte_ready,
	input  logic                                   from_aux,
	input  logic [7:0]                             data_byte,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [8:0]                      move_x,
	output logic signed [9:0]                      move_y,
	output logic [2:0]                             button_bits,
	output logic [POSITION_BITS-1:0]               cursor_x_out,
	output logic [POSITION_BITS-1:0]               cursor_y_out,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ps2mpt_pkg::INDEX_BITS-1:0]      cfg_index,
	input  logic [ps2mpt_pkg::BOUND_BITS-1:0]      cfg_data
);
	import ps2mpt_pkg::*;

	logic    q_full;
	logic    q_empty;
	logic    q_pop;
	logic    push;
	pkt_t    push_data;
	pkt_t    pop_data;
	cfg_wr_t cfg_wr;

	assign in_stall  = q_full;
	// bound writes wait until no packet is queued
	assign cfg_ready = q_empty;

	always_comb begin
		cfg_wr.valid = cfg_valid && cfg_ready;
		cfg_wr.index = cfg_index;
		cfg_wr.data  = cfg_data;
	end

	ps2mpt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_valid && !in_stall),
		.byte_ready (byte_ready),
		.from_aux   (from_aux),
		.data_byte  (data_byte),
		.push       (push),
		.push_data  (push_data)
	);

	ps2mpt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	ps2mpt_back #(
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr       (cfg_wr),
		.q_empty      (q_empty),
		.q_data       (pop_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.move_x       (move_x),
		.move_y       (move_y),
		.button_bits  (button_bits),
		.cursor_x_out (cursor_x_out),
		.cursor_y_out (cursor_y_out)
	);

endmodule

>>> sv/ps2mpt_front.sv
// front end: byte filtering, packet assembly and movement decode
module ps2mpt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               byte_ready,
	input  logic               from_aux,
	input  logic [7:0]         data_byte,
	output logic               push,
	output ps2mpt_pkg::pkt_t   push_data
);
	import ps2mpt_pkg::*;

	localparam logic [1:0] PH_FLAG = 2'd0;
	localparam logic [1:0] PH_X    = 2'd1;
	localparam logic [1:0] PH_Y    = 2'd2;

	logic [1:0] phase_q;
	logic [7:0] flag_q;
	logic [7:0] xbyte_q;
	logic       mouse_byte;
	logic signed [8:0] raw_y;

	assign mouse_byte = accept && byte_ready && from_aux;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG;
			flag_q  <= '0;
			xbyte_q <= '0;
		end else if (mouse_byte) begin
			case (phase_q)
				PH_X: begin
					xbyte_q <= data_byte;
					phase_q <= PH_Y;
				end
				PH_Y: begin
					phase_q <= PH_FLAG;
				end
				default: begin
					if (data_byte[SYNC_BIT]) begin
						flag_q  <= data_byte;
						phase_q <= PH_X;
					end else begin
						phase_q <= PH_FLAG;
					end
				end
			endcase
		end
	end

	assign raw_y = $signed({flag_q[Y_SIGN_BIT], data_byte});

	always_comb begin
		push_data.move_x      = $signed({flag_q[X_SIGN_BIT], xbyte_q});
		push_data.move_y      = -(10'(raw_y));
		push_data.button_bits = flag_q[2:0];
	end

	assign push = mouse_byte && (phase_q == PH_Y)
		&& !flag_q[X_OVFL_BIT] && !flag_q[Y_OVFL_BIT];

endmodule

>>> sv/ps2mpt_queue.sv
// small packet queue between front end and cursor update
module ps2mpt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ps2mpt_pkg::pkt_t push_data,
	output logic             full,
	input  logic             pop,
	output ps2mpt_pkg::pkt_t pop_data,
	output logic             empty
);
	import ps2mpt_pkg::*;

	pkt_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full     = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_BITS+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("packet pushed into full queue");

	a_pop_moves_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not lower count");

endmodule

>>> sv/ps2mpt_back.sv
// back end: bound registers, cursor update and clamping, result register
module ps2mpt_back #(
	parameter int POSITION_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ps2mpt_pkg::cfg_wr_t        cfg_wr,
	input  logic                       q_empty,
	input  ps2mpt_pkg::pkt_t           q_data,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [8:0]          move_x,
	output logic signed [9:0]          move_y,
	output logic [2:0]                 button_bits,
	output logic [POSITION_BITS-1:0]   cursor_x_out,
	output logic [POSITION_BITS-1:0]   cursor_y_out
);
	import ps2mpt_pkg::*;

	localparam int WB   = (POSITION_BITS + 1 > BOUND_BITS) ? POSITION_BITS + 1 : BOUND_BITS;
	localparam int SPAN = 1 << POSITION_BITS;
	localparam int EFF_W = (WIDTH_RESET > SPAN) ? SPAN : WIDTH_RESET;
	localparam int EFF_H = (HEIGHT_RESET > SPAN) ? SPAN : HEIGHT_RESET;
	localparam int RST_X = (WIDTH_RESET / 2 < EFF_W) ? WIDTH_RESET / 2 : EFF_W - 1;
	localparam int RST_Y = (HEIGHT_RESET / 2 < EFF_H) ? HEIGHT_RESET / 2 : EFF_H - 1;
	localparam int SW   = POSITION_BITS + 2;

	function automatic logic [POSITION_BITS-1:0] bound_max(input logic [BOUND_BITS-1:0] b);
		logic [WB-1:0] ext;
		logic [WB-1:0] span;
		logic [WB-1:0] m;
		ext  = WB'(b);
		span = WB'(1) << POSITION_BITS;
		if (ext == '0) begin
			m = '0;
		end else if (ext > span) begin
			m = span - 1'b1;
		end else begin
			m = ext - 1'b1;
		end
		return m[POSITION_BITS-1:0];
	endfunction

	function automatic logic [POSITION_BITS-1:0] clamp_sum(
		input logic signed [SW-1:0] s,
		input logic [POSITION_BITS-1:0] mx
	);
		logic [POSITION_BITS-1:0] r;
		if (s < 0) begin
			r = '0;
		end else if (s > $signed({2'b00, mx})) begin
			r = mx;
		end else begin
			r = s[POSITION_BITS-1:0];
		end
		return r;
	endfunction

	logic [POSITION_BITS-1:0] max_x_q;
	logic [POSITION_BITS-1:0] max_y_q;
	logic [POSITION_BITS-1:0] cursor_x_q;
	logic [POSITION_BITS-1:0] cursor_y_q;
	logic [POSITION_BITS-1:0] new_max;
	logic [POSITION_BITS-1:0] next_x;
	logic [POSITION_BITS-1:0] next_y;
	logic signed [SW-1:0]     sum_x;
	logic signed [SW-1:0]     sum_y;
	logic                     out_valid_q;

	assign q_pop   = !q_empty && (!out_valid_q || !out_stall);
	assign new_max = bound_max(cfg_wr.data);
	assign sum_x   = $signed({2'b00, cursor_x_q}) + SW'(q_data.move_x);
	assign sum_y   = $signed({2'b00, cursor_y_q}) + SW'(q_data.move_y);
	assign next_x  = clamp_sum(sum_x, max_x_q);
	assign next_y  = clamp_sum(sum_y, max_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q     <= bound_max(BOUND_BITS'(WIDTH_RESET));
			max_y_q     <= bound_max(BOUND_BITS'(HEIGHT_RESET));
			cursor_x_q  <= POSITION_BITS'(RST_X);
			cursor_y_q  <= POSITION_BITS'(RST_Y);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr.valid && cfg_wr.index == REG_SCREEN_WIDTH) begin
				max_x_q <= new_max;
				if (cursor_x_q > new_max) begin
					cursor_x_q <= new_max;
				end
			end else if (cfg_wr.valid && cfg_wr.index == REG_SCREEN_HEIGHT) begin
				max_y_q <= new_max;
				if (cursor_y_q > new_max) begin
					cursor_y_q <= new_max;
				end
			end else if (q_pop) begin
				cursor_x_q <= next_x;
				cursor_y_q <= next_y;
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			move_x       <= q_data.move_x;
			move_y       <= q_data.move_y;
			button_bits  <= q_data.button_bits;
			cursor_x_out <= next_x;
			cursor_y_out <= next_y;
		end
	end

	assign out_valid = out_valid_q;

	a_cursor_x_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_x_q <= max_x_q)
		else $error("cursor x beyond bound");

	a_cursor_y_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_y_q <= max_y_q)
		else $error("cursor y beyond bound");

	a_result_matches_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (cursor_x_out == cursor_x_q && cursor_y_out == cursor_y_q))
		else $error("result position differs from held cursor");

endmodule
